// ===== src/wmcs_pkg.sv =====
// ---------------------------------------------------------------------------
// wmcs_pkg
// Shared types, codes and command strings of the mux command sequencer.
// ---------------------------------------------------------------------------
package wmcs_pkg;

    // Response buffer
    localparam int RESP_DEPTH = 32;
    localparam int RESP_AW    = $clog2(RESP_DEPTH);
    localparam int RESP_CW    = $clog2(RESP_DEPTH + 1);

    // Queue between front and back end
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Input actions
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_MOD  = 2'd1;
    localparam logic [1:0] ACT_HOST = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_MOD_BYTE = 2'd0;
    localparam logic [1:0] KIND_PAY_BYTE = 2'd1;
    localparam logic [1:0] KIND_PAY_END  = 2'd2;

    // Characters
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_ACK   = 8'h4B;  // 'K'
    localparam logic [7:0] CH_ERR   = 8'h45;  // 'E'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_LOW_R = 8'h72;  // 'r'

    typedef enum logic [2:0] {
        STR_HTTP   = 3'd0,  // "1h"
        STR_NOTIFY = 3'd1,  // "W1r"
        STR_READ   = 3'd2,  // "1rb~80"
        STR_SEND   = 3'd3,  // "1sb~"
        STR_ABORT  = 3'd4,  // "1k"
        STR_END    = 3'd5,  // "1e"
        STR_TILDE  = 3'd6   // "~"
    } str_id_t;

    // One queued job: a whole command string or a single result
    typedef struct packed {
        logic       is_str;
        str_id_t    str_id;
        logic [1:0] kind;
        logic [7:0] value;
    } desc_t;

    // Command strings with trailing CR, first character in the lowest byte
    function automatic logic [55:0] str_bytes(str_id_t id);
        logic [55:0] s;
        begin
            s = '0;
            unique case (id)
                STR_HTTP:   s = {32'd0, CH_CR, "h", "1"};
                STR_NOTIFY: s = {24'd0, CH_CR, "r", "1", "W"};
                STR_READ:   s = {CH_CR, "0", "8", "~", "b", "r", "1"};
                STR_SEND:   s = {16'd0, CH_CR, "~", "b", "s", "1"};
                STR_ABORT:  s = {32'd0, CH_CR, "k", "1"};
                STR_END:    s = {32'd0, CH_CR, "e", "1"};
                STR_TILDE:  s = {40'd0, CH_CR, "~"};
                default:    s = '0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [7:0] str_char(str_id_t id, logic [2:0] pos);
        logic [55:0] s;
        begin
            s = str_bytes(id);
            return s[{pos, 3'b000} +: 8];
        end
    endfunction

    // Position of the closing CR
    function automatic logic [2:0] str_last_pos(str_id_t id);
        logic [2:0] p;
        begin
            p = 3'd0;
            unique case (id)
                STR_HTTP:   p = 3'd2;
                STR_NOTIFY: p = 3'd3;
                STR_READ:   p = 3'd6;
                STR_SEND:   p = 3'd4;
                STR_ABORT:  p = 3'd2;
                STR_END:    p = 3'd2;
                STR_TILDE:  p = 3'd1;
                default:    p = 3'd0;
            endcase
            return p;
        end
    endfunction

endpackage

// ===== src/wmcs_front.sv =====
// ---------------------------------------------------------------------------
// wmcs_front
// Accepts items, runs the exchange state machine and queues result jobs.
// ---------------------------------------------------------------------------
module wmcs_front
    import wmcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [1:0] action,
    input  logic [7:0] data,
    input  logic       final_byte,
    input  logic [7:0] term_char,
    output logic       push,
    output desc_t      push_desc
);

    typedef enum logic [3:0] {
        PH_SET_HTTP  = 4'd0,
        PH_NOTIFY    = 4'd1,
        PH_ACK       = 4'd2,
        PH_WAIT_CONN = 4'd3,
        PH_READ_CMD  = 4'd4,
        PH_PAYLOAD   = 4'd5,
        PH_SEND_CMD  = 4'd6,
        PH_SEND_DATA = 4'd7,
        PH_END       = 4'd8
    } phase_t;

    phase_t             phase_reg, phase_next;
    phase_t             after_ack_reg, after_ack_next;
    logic               error_seen_reg, error_seen_next;
    logic               connect_match_reg, connect_match_next;
    logic [7:0]         payload_count_reg, payload_count_next;
    logic               response_ready_reg, response_ready_next;
    logic [RESP_CW-1:0] response_count_reg, response_count_next;
    logic [RESP_CW-1:0] response_read_reg, response_read_next;
    logic [7:0]         store_mem [RESP_DEPTH];
    logic               store_we;
    logic [RESP_AW-1:0] store_wr_addr;
    logic [RESP_AW-1:0] store_rd_addr;
    logic [7:0]         store_rd_reg;

    // Read the entry that the read pointer holds after this edge
    assign store_wr_addr = response_count_reg[RESP_AW-1:0];
    assign store_rd_addr = aresetn ? response_read_next[RESP_AW-1:0] : '0;

    function automatic desc_t str_job(str_id_t id);
        desc_t d;
        begin
            d        = '0;
            d.is_str = 1'b1;
            d.str_id = id;
            d.kind   = KIND_MOD_BYTE;
            return d;
        end
    endfunction

    always_comb begin
        phase_next          = phase_reg;
        after_ack_next      = after_ack_reg;
        error_seen_next     = error_seen_reg;
        connect_match_next  = connect_match_reg;
        payload_count_next  = payload_count_reg;
        response_ready_next = response_ready_reg;
        response_count_next = response_count_reg;
        response_read_next  = response_read_reg;
        store_we            = 1'b0;
        push                = 1'b0;
        push_desc           = '0;

        if (accept) begin
            unique case (action)
                ACT_TICK: begin
                    unique case (phase_reg)
                        PH_SET_HTTP: begin
                            push           = 1'b1;
                            push_desc      = str_job(STR_HTTP);
                            phase_next     = PH_ACK;
                            after_ack_next = PH_NOTIFY;
                        end
                        PH_NOTIFY: begin
                            push               = 1'b1;
                            push_desc          = str_job(STR_NOTIFY);
                            phase_next         = PH_ACK;
                            after_ack_next     = PH_WAIT_CONN;
                            connect_match_next = 1'b0;
                        end
                        PH_READ_CMD: begin
                            push               = 1'b1;
                            push_desc          = str_job(STR_READ);
                            phase_next         = PH_ACK;
                            after_ack_next     = PH_PAYLOAD;
                            payload_count_next = 8'd0;
                        end
                        PH_SEND_CMD: begin
                            if (response_ready_reg) begin
                                push                = 1'b1;
                                push_desc           = str_job(STR_SEND);
                                response_ready_next = 1'b0;
                                phase_next          = PH_ACK;
                                after_ack_next      = PH_SEND_DATA;
                            end
                        end
                        PH_SEND_DATA: begin
                            push = 1'b1;
                            if (response_read_reg < response_count_reg) begin
                                push_desc.kind     = KIND_MOD_BYTE;
                                push_desc.value    = store_rd_reg;
                                response_read_next = response_read_reg + 1'b1;
                            end else begin
                                push_desc           = str_job(STR_TILDE);
                                response_count_next = '0;
                                response_read_next  = '0;
                                phase_next          = PH_ACK;
                                after_ack_next      = PH_END;
                            end
                        end
                        PH_END: begin
                            push           = 1'b1;
                            push_desc      = str_job(STR_END);
                            phase_next     = PH_SET_HTTP;
                            after_ack_next = PH_SET_HTTP;
                        end
                        default: ;
                    endcase
                end
                ACT_MOD: begin
                    unique case (phase_reg)
                        PH_ACK: begin
                            if (data == CH_ACK) begin
                                phase_next = after_ack_reg;
                            end else if (data == CH_ERR && !error_seen_reg) begin
                                error_seen_next = 1'b1;
                            end else if (error_seen_reg && data == CH_LF) begin
                                // abort and start over
                                error_seen_next = 1'b0;
                                push            = 1'b1;
                                push_desc       = str_job(STR_ABORT);
                                phase_next      = PH_SET_HTTP;
                            end
                        end
                        PH_WAIT_CONN: begin
                            if (!connect_match_reg) begin
                                if (data == CH_ONE) begin
                                    connect_match_next = 1'b1;
                                end
                            end else if (data == CH_LOW_R) begin
                                phase_next = PH_READ_CMD;
                            end
                        end
                        PH_PAYLOAD: begin
                            push = 1'b1;
                            if (data == term_char) begin
                                push_desc.kind  = KIND_PAY_END;
                                push_desc.value = payload_count_reg;
                                phase_next      = PH_SEND_CMD;
                            end else begin
                                push_desc.kind  = KIND_PAY_BYTE;
                                push_desc.value = data;
                                if (payload_count_reg != 8'hFF) begin
                                    payload_count_next = payload_count_reg + 8'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                ACT_HOST: begin
                    if (response_count_reg < RESP_CW'(RESP_DEPTH)) begin
                        store_we            = 1'b1;
                        response_count_next = response_count_reg + 1'b1;
                    end
                    if (final_byte) begin
                        response_ready_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_SET_HTTP;
            after_ack_reg      <= PH_SET_HTTP;
            error_seen_reg     <= 1'b0;
            connect_match_reg  <= 1'b0;
            payload_count_reg  <= 8'd0;
            response_ready_reg <= 1'b0;
            response_count_reg <= '0;
            response_read_reg  <= '0;
        end else begin
            phase_reg          <= phase_next;
            after_ack_reg      <= after_ack_next;
            error_seen_reg     <= error_seen_next;
            connect_match_reg  <= connect_match_next;
            payload_count_reg  <= payload_count_next;
            response_ready_reg <= response_ready_next;
            response_count_reg <= response_count_next;
            response_read_reg  <= response_read_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_wr_addr] <= data;
        end
        // forward a byte written to the entry that is read next
        if (store_we && store_wr_addr == store_rd_addr) begin
            store_rd_reg <= data;
        end else begin
            store_rd_reg <= store_mem[store_rd_addr];
        end
    end

    a_read_behind_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        response_read_reg <= response_count_reg)
        else $error("response read pointer passed the fill count");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        response_count_reg <= RESP_CW'(RESP_DEPTH))
        else $error("response fill count beyond buffer depth");

    a_single_job: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> accept && action != ACT_HOST)
        else $error("job queued without an accepted tick or module byte");

endmodule

// ===== src/wmcs_queue.sv =====
// ---------------------------------------------------------------------------
// wmcs_queue
// Short job queue between the front end and the output sequencer.
// ---------------------------------------------------------------------------
module wmcs_queue
    import wmcs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t head,
    output logic  full,
    output logic  empty
);

    desc_t           slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;

    assign full  = (count_reg == Q_CW'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== src/wmcs_back.sv =====
// ---------------------------------------------------------------------------
// wmcs_back
// Expands queued jobs into result transfers, one byte per unstalled cycle.
// ---------------------------------------------------------------------------
module wmcs_back
    import wmcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  desc_t       head,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic [2:0]  pos_reg, pos_next;
    logic        valid_reg;
    logic [15:0] data_reg;
    logic [1:0]  user_reg;
    logic        last_reg;
    logic        out_free;
    logic        job_last;
    logic [7:0]  byte_out;
    logic [7:0]  length_out;

    assign out_free = !valid_reg || m_tready;
    assign job_last = !head.is_str || (pos_reg == str_last_pos(head.str_id));
    assign pop      = out_free && head_valid && job_last;

    always_comb begin
        byte_out   = 8'd0;
        length_out = 8'd0;
        if (head.is_str) begin
            byte_out = str_char(head.str_id, pos_reg);
        end else if (head.kind == KIND_PAY_END) begin
            length_out = head.value;
        end else begin
            byte_out = head.value;
        end
        pos_next = pos_reg;
        if (out_free && head_valid) begin
            pos_next = job_last ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (out_free) begin
                valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && head_valid) begin
            data_reg <= {length_out, byte_out};
            user_reg <= head.kind;
            last_reg <= job_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    a_mid_string_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 3'd0 |-> head_valid && head.is_str)
        else $error("string position advanced without a string job");

    a_pos_in_string: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 3'd0 |-> pos_reg <= str_last_pos(head.str_id))
        else $error("string position beyond closing CR");

    a_last_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        out_free && head_valid && !job_last |=> head_valid && pos_reg != 3'd0)
        else $error("string job dropped before its CR");

endmodule

// ===== src/wifi_mux_command_sequencer.sv =====
// ---------------------------------------------------------------------------
// wifi_mux_command_sequencer
// Mux command exchange for a serial WiFi module, front end plus byte sequencer.
// ---------------------------------------------------------------------------
// Each input transfer is a tick, a byte from the module or a host response
// byte. The front end takes one transfer per clock while its four-entry job
// queue has room and updates the exchange state in that same cycle; a tick or
// module byte that calls for output queues one job (a command string ending
// in CR, one buffered response byte, one payload byte or a payload end
// marker). The back end drains the queue at one output transfer per clock
// while m_tready is high; most items have none or one result, "~" CR has 2,
// a command string 3 to 7, the longest being "1rb~80" CR. The first result
// of an item passes through the job queue and then the output register.
// The output byte rate of the back end sets sustained throughput; the
// output register holds a result while m_tready is low, and the front end
// keeps taking transfers until the queue fills. m_tlast marks the last
// result of an item. term_char is loaded through the cfg channel, always
// ready; the user must load it only while idle, the block does not enforce it.
// ---------------------------------------------------------------------------
module wifi_mux_command_sequencer
    import wmcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: term_char
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic        s_tlast,   // final_byte

    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] byte_out, [15:8] payload_length
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // run_last
);

    logic [7:0] term_char_reg;
    logic       accept;
    logic       push;
    desc_t      push_desc;
    desc_t      head;
    logic       q_full;
    logic       q_empty;
    logic       pop;

    // Register write: always accept
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_char_reg <= 8'd0;
        end else if (cfg_valid) begin
            term_char_reg <= cfg_data;
        end
    end

    // Hold input while the job queue is full
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    wmcs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .action     (s_tuser),
        .data       (s_tdata),
        .final_byte (s_tlast),
        .term_char  (term_char_reg),
        .push       (push),
        .push_desc  (push_desc)
    );

    wmcs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Advance through the head job one byte per output transfer
    wmcs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!q_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== tb/wmcs_checker.sv =====
// ---------------------------------------------------------------------------
// wmcs_checker
// Watches the config, input and result channels of the mux command
// sequencer, predicts the byte stream from every accepted input transfer and
// compares each result transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module wmcs_checker
    import wmcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic        s_tlast,   // final_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] byte_out, [15:8] payload_length
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        m_tlast,   // run_last
    output int          errors,
    output int          pending
);

    typedef enum logic [3:0] {
        SEQ_HTTP      = 4'd0,
        SEQ_NOTIFY    = 4'd1,
        SEQ_ACK       = 4'd2,
        SEQ_WAIT_CONN = 4'd3,
        SEQ_READ_CMD  = 4'd4,
        SEQ_PAYLOAD   = 4'd5,
        SEQ_SEND_CMD  = 4'd6,
        SEQ_SEND_DATA = 4'd7,
        SEQ_END       = 4'd8
    } seq_phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic [7:0] length;
        logic       last;
    } seq_out_t;

    seq_out_t   out_due_q[$];   // predictions not yet matched
    seq_out_t   step_q[$];      // results of the item being predicted

    logic [7:0] term_char;
    seq_phase_t phase;
    seq_phase_t after_ack;
    logic       err_seen;
    logic       conn_match;
    logic [7:0] pay_cnt;
    logic       resp_ready;
    logic [7:0] resp_store [RESP_DEPTH];
    int         resp_cnt;
    int         resp_rd;

    function automatic void emit(logic [1:0] k, logic [7:0] b, logic [7:0] len);
        step_q.push_back('{kind: k, byte_out: b, length: len, last: 1'b0});
    endfunction

    function automatic void emit_cmd(string s);
        for (int i = 0; i < s.len(); i++)
            emit(KIND_MOD_BYTE, s[i], 8'd0);
        emit(KIND_MOD_BYTE, CH_CR, 8'd0);
    endfunction

    function automatic void tick_step();
        case (phase)
            SEQ_HTTP: begin
                emit_cmd("1h");
                phase     = SEQ_ACK;
                after_ack = SEQ_NOTIFY;
            end
            SEQ_NOTIFY: begin
                emit_cmd("W1r");
                phase      = SEQ_ACK;
                after_ack  = SEQ_WAIT_CONN;
                conn_match = 1'b0;
            end
            SEQ_READ_CMD: begin
                emit_cmd("1rb~80");
                phase     = SEQ_ACK;
                after_ack = SEQ_PAYLOAD;
                pay_cnt   = 8'd0;
            end
            SEQ_SEND_CMD: begin
                if (resp_ready) begin
                    emit_cmd("1sb~");
                    resp_ready = 1'b0;
                    phase      = SEQ_ACK;
                    after_ack  = SEQ_SEND_DATA;
                end
            end
            SEQ_SEND_DATA: begin
                if (resp_rd < resp_cnt && resp_rd < RESP_DEPTH) begin
                    emit(KIND_MOD_BYTE, resp_store[resp_rd], 8'd0);
                    resp_rd++;
                end else begin
                    emit_cmd("~");
                    resp_cnt  = 0;
                    resp_rd   = 0;
                    phase     = SEQ_ACK;
                    after_ack = SEQ_END;
                end
            end
            SEQ_END: begin
                emit_cmd("1e");
                phase     = SEQ_HTTP;
                after_ack = SEQ_HTTP;
            end
            default: ;
        endcase
    endfunction

    function automatic void module_byte_step(logic [7:0] ch);
        case (phase)
            SEQ_ACK: begin
                if (ch == CH_ACK) begin
                    phase = after_ack;
                end else if (ch == CH_ERR && !err_seen) begin
                    err_seen = 1'b1;
                end else if (err_seen && ch == CH_LF) begin
                    // abort and restart from http mode
                    err_seen = 1'b0;
                    emit_cmd("1k");
                    phase = SEQ_HTTP;
                end
            end
            SEQ_WAIT_CONN: begin
                if (!conn_match) begin
                    if (ch == CH_ONE)
                        conn_match = 1'b1;
                end else if (ch == CH_LOW_R) begin
                    phase = SEQ_READ_CMD;
                end
            end
            SEQ_PAYLOAD: begin
                if (ch == term_char) begin
                    emit(KIND_PAY_END, 8'd0, pay_cnt);
                    phase = SEQ_SEND_CMD;
                end else begin
                    emit(KIND_PAY_BYTE, ch, 8'd0);
                    if (pay_cnt != 8'd255)
                        pay_cnt++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_item(logic [1:0] act, logic [7:0] d, logic fin);
        step_q.delete();
        case (act)
            ACT_TICK: tick_step();
            ACT_MOD:  module_byte_step(d);
            ACT_HOST: begin
                if (resp_cnt < RESP_DEPTH) begin
                    resp_store[resp_cnt] = d;
                    resp_cnt++;
                end
                if (fin)
                    resp_ready = 1'b1;
            end
            default: ;
        endcase
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            out_due_q.push_back(step_q[i]);
    endfunction

    function automatic void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%02h, got 0x%02h",
                     $time, name, exp_v, act_v);
        end
    endfunction

    function automatic void check_result();
        seq_out_t e;
        if (out_due_q.size() == 0) begin
            errors++;
            $display({"%0t: unexpected result: expected none, ",
                      "got kind %0d byte 0x%02h len %0d last %0b"},
                     $time, m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
            return;
        end
        e = out_due_q.pop_front();
        cmp_field("kind", 8'(e.kind), 8'(m_tuser));
        cmp_field("byte_out", e.byte_out, m_tdata[7:0]);
        cmp_field("payload_length", e.length, m_tdata[15:8]);
        cmp_field("run_last", 8'(e.last), 8'(m_tlast));
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            term_char  = 8'd0;
            phase      = SEQ_HTTP;
            after_ack  = SEQ_HTTP;
            err_seen   = 1'b0;
            conn_match = 1'b0;
            pay_cnt    = 8'd0;
            resp_ready = 1'b0;
            resp_cnt   = 0;
            resp_rd    = 0;
            out_due_q.delete();
        end else begin
            // results first: nothing accepted at this edge can show up yet
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_valid && cfg_ready)
                term_char = cfg_data;
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata, s_tlast);
        end
        pending = out_due_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the mux command sequencer: a directed walk through
// one full exchange, then scripted exchanges with random content, filler
// items, aborts, buffer overflow and a long payload, under random idling.
// ---------------------------------------------------------------------------
module tb
    import wmcs_pkg::*;
();

    // Unused action code, ignored by the block
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Where filler items land, which decides what filler is harmless
    typedef enum int {
        FILL_TX,    // transmitting phase: no ticks
        FILL_ACK,   // awaiting acknowledge: no 'K', 'E' or newline
        FILL_WAIT,  // awaiting connection: no 'r'
        FILL_PAY    // payload: no module bytes
    } fill_ctx_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [7:0] data
    logic [1:0]  s_tuser   = 2'd0;   // [1:0] action
    logic        s_tlast   = 1'b0;   // final_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // [7:0] byte_out, [15:8] payload_length
    logic [1:0]  m_tuser;            // [1:0] kind
    logic        m_tlast;            // run_last

    int errors;
    int pending;

    // Stimulus-side view of the exchange, just enough to script it
    logic [7:0] term      = 8'd0;
    int         host_cnt  = 0;
    bit         host_rdy  = 1'b0;
    int         burst_left = 0;
    int         n_items   = 0;

    wifi_mux_command_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    wmcs_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver stalls: switch between always ready, coin flip, mostly
    // stalled and a fixed one-in-four pattern, each for a random stretch
    initial begin : rx_stall
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(8, 80);
            end
            left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (left % 4 == 0);
            endcase
        end
    end

    // Present one item and hold it until the transfer; insert a gap of
    // random length whenever a burst runs out
    task automatic send_item(input logic [1:0] act, input logic [7:0] d, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        n_items++;
    endtask

    // Tick and module bytes carry random filler in the unused fields
    task automatic send_tick();
        send_item(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_module_byte(input logic [7:0] d);
        send_item(ACT_MOD, d, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_host_byte(input logic [7:0] d, input logic fin);
        send_item(ACT_HOST, d, fin);
        if (host_cnt < RESP_DEPTH)
            host_cnt++;
        if (fin)
            host_rdy = 1'b1;
    endtask

    // Zero to three items that leave the exchange where it is
    task automatic send_filler(input fill_ctx_t where);
        int n;
        logic [7:0] d;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: send_item(ACT_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                1: send_host_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
                2: begin
                    if (where == FILL_TX)
                        send_item(ACT_NONE, 8'($urandom_range(0, 255)), 1'b0);
                    else
                        send_tick();
                end
                default: begin
                    case (where)
                        FILL_TX: send_module_byte(8'($urandom_range(0, 255)));
                        FILL_ACK: begin
                            do d = 8'($urandom_range(0, 255));
                            while (d == CH_ACK || d == CH_ERR || d == CH_LF);
                            send_module_byte(d);
                        end
                        FILL_WAIT: begin
                            do d = 8'($urandom_range(0, 255)); while (d == CH_LOW_R);
                            send_module_byte(d);
                        end
                        default: send_tick();
                    endcase
                end
            endcase
        end
    endtask

    // Acknowledge the last command; now and then raise an error first,
    // and now and then abort with 'E' then newline instead
    task automatic await_ack(output bit aborted);
        aborted = 1'b0;
        send_filler(FILL_ACK);
        case ($urandom_range(0, 15))
            0: begin
                send_module_byte(CH_ERR);
                send_filler(FILL_ACK);
                send_module_byte(CH_LF);
                aborted = 1'b1;
            end
            1: begin
                send_module_byte(CH_ERR);
                send_filler(FILL_ACK);
                send_module_byte(CH_ACK);
            end
            default: send_module_byte(CH_ACK);
        endcase
    endtask

    // One exchange from http mode to the end command; an abort drops back
    // to http mode, which is where the next exchange starts
    task automatic run_exchange(input int pay_len);
        bit ab;
        int n;
        int sent;
        logic [7:0] d;

        send_filler(FILL_TX);
        send_tick();                      // http mode
        await_ack(ab);
        if (ab) return;
        send_filler(FILL_TX);
        send_tick();                      // connect notify
        await_ack(ab);
        if (ab) return;

        send_filler(FILL_WAIT);
        send_module_byte(CH_ONE);
        send_filler(FILL_WAIT);
        send_module_byte(CH_LOW_R);

        send_filler(FILL_TX);
        send_tick();                      // read command
        await_ack(ab);
        if (ab) return;

        // Keep a long payload free of filler
        for (int i = 0; i < pay_len; i++) begin
            if (pay_len < 256)
                send_filler(FILL_PAY);
            do d = 8'($urandom_range(0, 255)); while (d == term);
            send_module_byte(d);
        end
        send_module_byte(term);

        // Send command: tick first without a ready response now and then
        send_filler(FILL_TX);
        if (!host_rdy && $urandom_range(0, 1) == 1)
            send_tick();
        n = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8);
        for (int i = 1; i <= n; i++)
            send_host_byte(8'($urandom_range(0, 255)), i == n);
        send_tick();
        host_rdy = 1'b0;
        await_ack(ab);
        if (ab) return;

        // Send data: one tick per buffered byte, then "~" CR
        sent = 0;
        forever begin
            send_filler(FILL_TX);
            send_tick();
            if (sent < host_cnt) begin
                sent++;
            end else begin
                host_cnt = 0;
                break;
            end
        end
        await_ack(ab);
        if (ab) return;

        send_filler(FILL_TX);
        send_tick();                      // end
    endtask

    // Stop sending and hold until every predicted result has arrived
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    task automatic write_term(input logic [7:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        term = v;
    endtask

    initial begin : stimulus
        int xchg;
        int pay_len;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed walk with the reset terminator of zero
        send_tick();                          // "1h" CR
        send_module_byte(CH_ERR);             // error pending
        send_module_byte(CH_ACK);             // ack still taken, error stays
        send_module_byte(8'h5A);              // dropped while transmitting
        send_tick();                          // "W1r" CR
        send_module_byte(CH_ACK);
        send_tick();                          // ignored while waiting
        send_module_byte(CH_ONE);
        send_module_byte(CH_LOW_R);
        send_tick();                          // "1rb~80" CR, longest command
        send_module_byte(CH_ACK);
        send_tick();                          // ignored in payload
        send_module_byte(8'hFF);
        send_module_byte(8'h01);
        send_module_byte(8'h00);              // terminator, length 2
        send_tick();                          // no response ready yet
        send_host_byte(8'hAA, 1'b0);
        send_host_byte(8'h55, 1'b1);
        send_item(ACT_NONE, 8'hFF, 1'b1);     // unused action
        send_tick();                          // "1sb~" CR
        send_module_byte(CH_ACK);
        send_tick();                          // buffered 0xAA
        send_tick();                          // buffered 0x55
        send_tick();                          // "~" CR
        host_cnt = 0;
        host_rdy = 1'b0;
        send_module_byte(CH_ACK);
        send_tick();                          // "1e" CR
        send_tick();                          // "1h" CR
        send_module_byte(CH_LF);              // error still pending: abort

        // Scripted exchanges with random content, the long payload first;
        // change the terminator between groups, extremes first, once the
        // block has drained
        xchg = 0;
        while (n_items < 220) begin
            if (xchg % 4 == 0) begin
                wait_idle();
                case ((xchg / 4) % 4)
                    0:       write_term(8'hFF);
                    1:       write_term(8'h00);
                    default: write_term(8'($urandom_range(0, 255)));
                endcase
            end
            if (xchg == 0) begin
                // long payload: the length saturates at 255
                run_exchange(256);
            end else begin
                pay_len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
                run_exchange(pay_len);
            end
            xchg++;
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/wmcs_pkg.sv
src/wmcs_front.sv
src/wmcs_queue.sv
src/wmcs_back.sv
src/wifi_mux_command_sequencer.sv
tb/wmcs_checker.sv
tb/tb.sv
